// ===== src/ctl_pkg.sv =====
// shared constants and types for the closed tour length block
// no dependencies
`default_nettype none

package ctl_pkg;

    // coordinate width default and fixed result format
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_PAIRS     = 8;
    localparam int SUM_W          = 35;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_SUM,
        S_ROOT,
        S_ACC,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== src/ctl_sqrt.sv =====
// bit-serial restoring square root, one root bit per cycle
// radicand shifts out two bits per cycle, zero pairs follow for fraction bits
// depends on ctl_pkg
`default_nettype none

module ctl_sqrt #(
    parameter int RAD_PAIRS  = ctl_pkg::COORD_BITS_DEF + 2,
    parameter int FRAC_PAIRS = ctl_pkg::FRAC_PAIRS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [2*RAD_PAIRS-1:0]            i_radicand,
    output logic                                   o_done,
    output logic [RAD_PAIRS+FRAC_PAIRS-1:0]        o_root
);
    import ctl_pkg::*;

    localparam int ROOT_W = RAD_PAIRS + FRAC_PAIRS;
    localparam int RAD_W  = 2 * RAD_PAIRS;
    localparam int REM_W  = ROOT_W + 3;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              fits;

    // bring down the next radicand pair and try the next root bit
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign diff   = {1'b0, rem_sh} - {1'b0, trial};
    assign fits   = ~diff[REM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= fits ? diff[REM_W-1:0] : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== src/closed_tour_length.sv =====
// closed tour length: a first point is only registered; a middle point passes accept,
// the DIFF, SQ and SUM steps, COORD_BITS + 10 root bits one per cycle, then ACC; a final
// point runs two legs (its own and the closing one) and then EMIT, which waits while
// an earlier result still waits at a stalled output. one item is worked on at a time; the
// output register lets the next item enter while a result waits. synchronous active-low
// reset clears the sequencer, tour flag, running sum and output valid. uses ctl_pkg, ctl_sqrt
`default_nettype none

module closed_tour_length #(
    parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // input item channel
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [COORD_BITS-1:0]        i_point_x,
    input  wire logic [COORD_BITS-1:0]        i_point_y,
    input  wire logic                         i_tour_end,
    // result item channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [ctl_pkg::SUM_W-1:0]         o_tour_length
);
    import ctl_pkg::*;

    // coordinate difference magnitude, square, radicand and root widths
    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int RAD_PAIRS = COORD_BITS + 2;
    localparam int RAD_W     = 2 * RAD_PAIRS;
    localparam int ROOT_W    = RAD_PAIRS + FRAC_PAIRS;

    t_state r_state, n_state;

    // tour state
    logic                  r_in_tour, n_in_tour;
    logic [COORD_BITS-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic [COORD_BITS-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [SUM_W-1:0]      r_len, n_len;

    // leg operands: from point a to point b
    logic [COORD_BITS-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic                  r_last, n_last;
    logic                  r_close, n_close;

    // datapath pipeline registers
    logic [DIFF_W-1:0]     r_dx, n_dx, r_dy, n_dy;
    logic [SQ_W-1:0]       r_sqx, n_sqx, r_sqy, n_sqy;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [SUM_W-1:0]      r_out, n_out;

    logic                  accept;
    logic                  out_free;
    logic [DIFF_W-1:0]     dx_raw, dy_raw;
    logic [RAD_W-1:0]      radicand;
    logic                  sqrt_start;
    logic                  sqrt_done;
    logic [ROOT_W-1:0]     leg;
    logic [SUM_W:0]        sum_wide;
    logic [SUM_W-1:0]      sum_sat;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // signed differences, sign-extended by one bit so they never overflow
    assign dx_raw = {r_bx[COORD_BITS-1], r_bx} - {r_ax[COORD_BITS-1], r_ax};
    assign dy_raw = {r_by[COORD_BITS-1], r_by} - {r_ay[COORD_BITS-1], r_ay};

    // squared distance, two bits wider than either square
    assign radicand = RAD_W'(r_sqx) + RAD_W'(r_sqy);

    // saturating accumulate: clamp once the sum reaches the all-ones value
    assign sum_wide = (SUM_W + 1)'(r_len) + (SUM_W + 1)'(leg);
    assign sum_sat  = (sum_wide >= {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    ctl_sqrt #(
        .RAD_PAIRS  (RAD_PAIRS),
        .FRAC_PAIRS (FRAC_PAIRS)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_done     (sqrt_done),
        .o_root     (leg)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (r_in_tour) begin
                        n_state = S_DIFF;
                    end else if (i_tour_end) begin
                        // single-point tour goes straight out with zero
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIFF: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_ROOT;
            S_ROOT: begin
                if (sqrt_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (r_last && !r_close) begin
                    // closing leg back to the first point
                    n_state = S_DIFF;
                end else if (r_last) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_in_tour   = r_in_tour;
        n_first_x   = r_first_x;
        n_first_y   = r_first_y;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_len       = r_len;
        n_ax        = r_ax;
        n_ay        = r_ay;
        n_bx        = r_bx;
        n_by        = r_by;
        n_last      = r_last;
        n_close     = r_close;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sqx       = r_sqx;
        n_sqy       = r_sqy;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        sqrt_start  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in_tour = !i_tour_end;
                    n_last    = i_tour_end;
                    n_close   = 1'b0;
                    n_prev_x  = i_point_x;
                    n_prev_y  = i_point_y;
                    if (!r_in_tour) begin
                        n_first_x = i_point_x;
                        n_first_y = i_point_y;
                        n_len     = '0;
                    end else begin
                        n_ax = r_prev_x;
                        n_ay = r_prev_y;
                        n_bx = i_point_x;
                        n_by = i_point_y;
                    end
                end
            end
            S_DIFF: begin
                n_dx = dx_raw[DIFF_W-1] ? (DIFF_W'(0) - dx_raw) : dx_raw;
                n_dy = dy_raw[DIFF_W-1] ? (DIFF_W'(0) - dy_raw) : dy_raw;
            end
            S_SQ: begin
                n_sqx = SQ_W'(r_dx) * SQ_W'(r_dx);
                n_sqy = SQ_W'(r_dy) * SQ_W'(r_dy);
            end
            S_SUM: begin
                sqrt_start = 1'b1;
            end
            S_ACC: begin
                n_len = sum_sat;
                if (r_last && !r_close) begin
                    n_ax    = r_bx;
                    n_ay    = r_by;
                    n_bx    = r_first_x;
                    n_by    = r_first_y;
                    n_close = 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_len;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                sqrt_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_tour   <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_tour   <= n_in_tour;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_first_x <= n_first_x;
        r_first_y <= n_first_y;
        r_prev_x  <= n_prev_x;
        r_prev_y  <= n_prev_y;
        r_ax      <= n_ax;
        r_ay      <= n_ay;
        r_bx      <= n_bx;
        r_by      <= n_by;
        r_last    <= n_last;
        r_close   <= n_close;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_sqx     <= n_sqx;
        r_sqy     <= n_sqy;
        r_out     <= n_out;
    end

    // input side waits whenever a point is in progress
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_tour_length = r_out;

endmodule

`default_nettype wire

// ===== test/closed_tour_length_chk.sv =====
`timescale 1ns / 1ps
// result checker for closed_tour_length: follows both item channels, predicts each tour length
// and compares it with the block's output; depends on ctl_pkg
module closed_tour_length_chk #(
    parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_stall,
    input  wire logic [COORD_BITS-1:0]     i_point_x,
    input  wire logic [COORD_BITS-1:0]     i_point_y,
    input  wire logic                      i_tour_end,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_stall,
    input  wire logic [ctl_pkg::SUM_W-1:0] i_tour_length,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ctl_pkg::*;

    logic [COORD_BITS-1:0] start_x, start_y, last_x, last_y;
    logic [SUM_W-1:0]      run_length;
    logic                  touring;
    logic [SUM_W-1:0]      want_length;
    logic [SUM_W-1:0]      tour_length_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // truncated distance between two points, 8 fraction bits, by restoring square root
    function automatic logic [SUM_W-1:0] leg_fixed(input logic [COORD_BITS-1:0] ax,
                                                    input logic [COORD_BITS-1:0] ay,
                                                    input logic [COORD_BITS-1:0] bx,
                                                    input logic [COORD_BITS-1:0] by);
        longint      dx, dy;
        logic [63:0] rad, root, rem, trial, pair;
        dx = longint'($signed(bx)) - longint'($signed(ax));
        dy = longint'($signed(by)) - longint'($signed(ay));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        rad  = dx * dx + dy * dy;
        root = '0;
        rem  = '0;
        for (int i = COORD_BITS + 2 + FRAC_PAIRS - 1; i >= 0; i--) begin
            pair  = (i >= FRAC_PAIRS) ? ((rad >> (2 * (i - FRAC_PAIRS))) & 64'd3) : 64'd0;
            rem   = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b);
        logic [SUM_W:0] total;
        total = {1'b0, a} + {1'b0, b};
        return (total >= {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_x    = '0;
            start_y    = '0;
            last_x     = '0;
            last_y     = '0;
            run_length = '0;
            touring    = 1'b0;
            tour_length_q.delete();
        end else begin
            // result side first, so a result never meets an expectation pushed this cycle
            if (i_out_valid && !i_out_stall) begin
                if (tour_length_q.size() == 0) begin
                    $error("unexpected tour_length item: actual %0d", i_tour_length);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_length = tour_length_q.pop_front();
                    if (want_length !== i_tour_length) begin
                        $error("tour_length mismatch: expected %0d, actual %0d",
                               want_length, i_tour_length);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (!touring) begin
                    start_x    = i_point_x;
                    start_y    = i_point_y;
                    run_length = '0;
                end else begin
                    run_length = add_sat(run_length,
                                         leg_fixed(last_x, last_y, i_point_x, i_point_y));
                end
                last_x = i_point_x;
                last_y = i_point_y;
                if (i_tour_end) begin
                    if (touring)
                        run_length = add_sat(run_length,
                                             leg_fixed(i_point_x, i_point_y, start_x, start_y));
                    tour_length_q.push_back(run_length);
                    touring = 1'b0;
                end else begin
                    touring = 1'b1;
                end
            end
        end
        o_pending = tour_length_q.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// top of the closed_tour_length testbench: clock, reset, tour stimulus and receiver stalls,
// with the verdict taken from closed_tour_length_chk; depends on ctl_pkg and the block
module tb;
    import ctl_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_CYCLES  = 800;
    localparam int DRAIN_CYCLES = 80;     // longer than two legs plus the output step
    localparam int CYCLE_LIMIT  = 2000000;

    localparam logic [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};

    logic             i_clk;
    logic             i_rst_n;
    logic             pt_valid;
    logic [CB-1:0]    pt_x;
    logic [CB-1:0]    pt_y;
    logic             pt_end;
    logic             len_stall;
    wire logic        pt_stall;
    wire logic        len_valid;
    wire [SUM_W-1:0]  tour_length;

    int               fail_count;
    int               pending;
    int unsigned      cycle_count = 0;
    int               burst_left  = 0;
    bit               hold_go     = 1'b0;
    bit               hold_done   = 1'b0;

    closed_tour_length #(
        .COORD_BITS (CB)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (pt_valid),
        .o_stall       (pt_stall),
        .i_point_x     (pt_x),
        .i_point_y     (pt_y),
        .i_tour_end    (pt_end),
        .o_valid       (len_valid),
        .i_stall       (len_stall),
        .o_tour_length (tour_length)
    );

    closed_tour_length_chk #(
        .COORD_BITS (CB)
    ) u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (pt_valid),
        .i_in_stall    (pt_stall),
        .i_point_x     (pt_x),
        .i_point_y     (pt_y),
        .i_tour_end    (pt_end),
        .i_out_valid   (len_valid),
        .i_out_stall   (len_stall),
        .i_tour_length (tour_length),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** closed_tour_length: FAILED **");
            $finish;
        end
    end

    // receiver: stall pattern is redrawn at random spans, plus one long hold-off
    // that lets results pile up until the block has to stall its input
    initial begin
        int mode;
        int span;
        int hold_cnt;
        len_stall = 1'b0;
        forever begin
            mode = $urandom_range(3);
            span = $urandom_range(32, 256);
            repeat (span) begin
                @(negedge i_clk);
                if (hold_go && !hold_done) begin
                    len_stall <= 1'b1;
                    hold_cnt = 0;
                    while (hold_cnt < HOLD_CYCLES) begin
                        @(negedge i_clk);
                        hold_cnt++;
                    end
                    hold_done = 1'b1;
                end else begin
                    case (mode)
                        0:       len_stall <= 1'b0;                      // free flowing
                        1:       len_stall <= ($urandom_range(3) == 0);  // light stalls
                        2:       len_stall <= ($urandom_range(3) != 0);  // heavy stalls
                        default: len_stall <= ($urandom_range(15) == 0); // rare stalls
                    endcase
                end
            end
        end
    end

    // one point item, sent in bursts with random gaps in between; returns once accepted
    task automatic put_point(input logic [CB-1:0] x, input logic [CB-1:0] y,
                             input logic last);
        int gap;
        if (burst_left == 0) begin
            // mostly short gaps, now and then a long one, often none at all
            gap        = ($urandom_range(7) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                @(negedge i_clk);
                pt_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        pt_valid <= 1'b1;
        pt_x     <= x;
        pt_y     <= y;
        pt_end   <= last;
        @(posedge i_clk);
        while (pt_stall) @(posedge i_clk);
    endtask

    // coordinate mix: full range, near the origin, and the extremes
    function automatic logic [CB-1:0] pick_coord();
        logic [CB-1:0] v;
        case ($urandom_range(7))
            0, 1, 2: v = CB'($urandom);
            3, 4:    v = CB'($urandom_range(64)) - CB'(32);
            5:       v = C_MIN;
            6:       v = C_MAX;
            default: v = $urandom_range(1) ? '0 : '1;
        endcase
        return v;
    endfunction

    initial begin
        int sent;
        int npts;
        int kind;
        i_rst_n  = 1'b0;
        pt_valid = 1'b0;
        pt_x     = '0;
        pt_y     = '0;
        pt_end   = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single-point tours give zero, also at the corners
        put_point('0, '0, 1'b1);
        put_point(C_MIN, C_MAX, 1'b1);
        // 3-4-5 triangle, exact length 12
        put_point('0, '0, 1'b0);
        put_point(CB'(3), '0, 1'b0);
        put_point(CB'(3), CB'(4), 1'b1);
        // longest leg, diagonal there and back
        put_point(C_MIN, C_MIN, 1'b0);
        put_point(C_MAX, C_MAX, 1'b1);
        // full-width horizontal legs
        put_point(C_MAX, '0, 1'b0);
        put_point(C_MIN, '0, 1'b0);
        put_point(C_MAX, '0, 1'b1);
        // repeated point, zero legs
        put_point(CB'(5), CB'(-7), 1'b0);
        put_point(CB'(5), CB'(-7), 1'b0);
        put_point(CB'(5), CB'(-7), 1'b1);
        // vertical extremes and mixed signs
        put_point('0, C_MAX, 1'b0);
        put_point('0, C_MIN, 1'b0);
        put_point('1, '1, 1'b0);
        put_point(CB'(1), CB'(1), 1'b1);
        put_point(C_MAX, C_MIN, 1'b0);
        put_point(C_MIN, C_MAX, 1'b1);
        // the next tour starts from zero again
        put_point(CB'(1), CB'(1), 1'b0);
        put_point(CB'(2), CB'(2), 1'b1);

        // random tours: mostly short, some single points, a few long ones
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= 100) hold_go = 1'b1;
            kind = $urandom_range(9);
            if (kind == 0)
                npts = 1;
            else if (kind == 1)
                npts = $urandom_range(20, 60);
            else
                npts = $urandom_range(2, 8);
            for (int k = 0; k < npts; k++) begin
                put_point(pick_coord(), pick_coord(), k == npts - 1);
                sent++;
            end
        end
        @(negedge i_clk);
        pt_valid <= 1'b0;

        // let outstanding results come back, then watch for strays
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** closed_tour_length: PASSED **");
        end else begin
            $display("** closed_tour_length: FAILED **");
        end
        $finish;
    end

endmodule
